>>> rtl/core/rde_pkg.sv
// Package for the row debounce block: sizing constants and the event slot type.
// Depends on nothing; used by every module of the block.
package rde_pkg;

    localparam int SAMPLES = 4;
    localparam int COLUMNS = 8;
    localparam int ROW_W   = 8;
    localparam int COL_W   = 3;

    // One pending key event as it travels down the cell chain.
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        logic             press;
    } ev_t;

    // Control from the top level to every cell.
    typedef struct packed {
        logic load;
        logic advance;
    } ctrl_t;

endpackage

>>> rtl/core/rde_cell.sv
// One column cell: sample history, debounced bit and one event slot of the chain.
// Depends on rde_pkg.
module rde_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [rde_pkg::COL_W-1:0] col_idx,
    input  logic                      sample_bit,
    input  rde_pkg::ctrl_t            ctrl,
    input  rde_pkg::ev_t              slot_in,
    input  logic                      above_in,
    output rde_pkg::ev_t              slot_out,
    output logic                      above_out
);
    import rde_pkg::*;

    logic [SAMPLES-1:0] ring_reg;
    logic [SAMPLES-1:0] ring_next;
    logic               deb_reg;
    logic               deb_next;
    ev_t                slot_reg;
    ev_t                slot_next;

    // The history is kept as a shift line; the debounce only looks at all bits.
    always_comb
    begin
        ring_next[0] = sample_bit;
        for (int i = 1; i < SAMPLES; i++)
        begin
            ring_next[i] = ring_reg[i-1];
        end
        deb_next = (&ring_next) | ((|ring_next) & deb_reg);
    end

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.load)
        begin
            slot_next.valid = deb_next ^ deb_reg;
            slot_next.col   = col_idx;
            slot_next.press = deb_next;
        end
        else if (ctrl.advance)
        begin
            slot_next = slot_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg <= '0;
            deb_reg  <= 1'b0;
            slot_reg <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                ring_reg <= ring_next;
                deb_reg  <= deb_next;
            end
            slot_reg <= slot_next;
        end
    end

    assign slot_out  = slot_reg;
    assign above_out = above_in | slot_reg.valid;

endmodule

>>> rtl/core/rde_out_reg.sv
// Output register for key events, taking the head of the cell chain.
// Depends on rde_pkg.
module rde_out_reg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rde_pkg::ev_t              head,
    input  logic                      head_last,
    input  logic                      stall,
    output logic                      take,
    output logic                      valid,
    output logic [rde_pkg::COL_W-1:0] key_column,
    output logic                      is_press,
    output logic                      last_event
);
    import rde_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [COL_W-1:0] col_reg;
    logic             press_reg;
    logic             last_reg;

    assign take       = head.valid & (~valid_reg | ~stall);
    assign valid_next = take | (valid_reg & stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            col_reg   <= head.col;
            press_reg <= head.press;
            last_reg  <= head_last;
        end
    end

    assign valid      = valid_reg;
    assign key_column = col_reg;
    assign is_press   = press_reg;
    assign last_event = last_reg;

endmodule

>>> rtl/core/row_debounce_edge_events.sv
// Top level of the row debounce block: a chain of column cells and an output register.
// Depends on rde_pkg, rde_cell and rde_out_reg.
//
// The block takes one raw row scan per transaction and debounces every column over
// the last four scans: a column reads closed once four scans in a row show it closed
// and open once four show it open. Each column whose debounced state changes yields
// one event transaction (column, press or release), in ascending column order, and
// the last event of a scan is flagged. A scan with no change gives no event. The
// events sit in a chain of one cell per column that moves one place toward the output
// each cycle unless its head event is held back by a stalled output register;
// sample_stall stays high until the last event of the scan has entered the output
// register. A scan that changes nothing leaves the chain empty, and the next one can
// be taken right after. The output register holds one finished event, so a new scan
// may enter while it waits.
module row_debounce_edge_events (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_stall,
    input  logic [rde_pkg::ROW_W-1:0] row_sample,
    output logic                      event_valid,
    input  logic                      event_stall,
    output logic [rde_pkg::COL_W-1:0] key_column,
    output logic                      is_press,
    output logic                      last_event
);
    import rde_pkg::*;

    ev_t   slot  [COLUMNS+1];
    logic  above [COLUMNS+1];
    ctrl_t ctrl;
    logic  take;

    // Sentinel beyond the top cell: an empty slot and nothing pending.
    assign slot[COLUMNS]  = '0;
    assign above[COLUMNS] = 1'b0;

    // A scan is taken only when the chain is empty; the chain then advances
    // whenever its head is empty or the head moves into the output register.
    assign sample_stall = above[0];
    assign ctrl.load    = sample_valid & ~above[0];
    assign ctrl.advance = ~slot[0].valid | take;

    for (genvar c = 0; c < COLUMNS; c++)
    begin : g_cell
        rde_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .col_idx   (COL_W'(c)),
            .sample_bit(row_sample[c]),
            .ctrl      (ctrl),
            .slot_in   (slot[c+1]),
            .above_in  (above[c+1]),
            .slot_out  (slot[c]),
            .above_out (above[c])
        );
    end

    // The head event is the last of its scan when no cell above it holds one.
    rde_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (slot[0]),
        .head_last (~above[1]),
        .stall     (event_stall),
        .take      (take),
        .valid     (event_valid),
        .key_column(key_column),
        .is_press  (is_press),
        .last_event(last_event)
    );

endmodule

>>> rtl/core/rde_checker.sv
// Port level checks for the row debounce block, bound to its top level.
// Depends on rde_pkg and row_debounce_edge_events.
module rde_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      sample_valid,
    input logic                      sample_stall,
    input logic [rde_pkg::ROW_W-1:0] row_sample,
    input logic                      event_valid,
    input logic                      event_stall,
    input logic [rde_pkg::COL_W-1:0] key_column,
    input logic                      is_press,
    input logic                      last_event
);
    import rde_pkg::*;

    // A stalled scan transaction keeps its payload until it is taken.
    a_scan_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_stall |=> sample_valid && $stable(row_sample))
        else $error("stalled scan changed");

    // A stalled event transaction keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_stall |=> event_valid && $stable(key_column)
            && $stable(is_press) && $stable(last_event))
        else $error("stalled event changed");

    // While an event that is not the last of its scan waits, no new scan enters.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && !last_event |-> sample_stall)
        else $error("new scan accepted before the current one drained");

    // The sample side opens only after the last event of a scan was presented.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(sample_stall) |-> event_valid && last_event)
        else $error("scan finished without a last event");

    // Events of one scan come in strictly ascending column order.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && !event_stall && !last_event |=>
            !event_valid || (key_column > $past(key_column)))
        else $error("event columns out of order");

endmodule

bind row_debounce_edge_events rde_checker u_rde_checker (.*);
